/* hdl/polygon_face_normal_core_defines.svh */
// Assertion macros shared by the polygon face normal RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef POLYGON_FACE_NORMAL_CORE_DEFINES_SVH
`define POLYGON_FACE_NORMAL_CORE_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define PFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its trigger.
`define PFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfn_pkg.sv */
// Shared types and constants of the polygon face normal block.
// Used by pfn_front, pfn_queue, pfn_back and polygon_face_normal_core.
`timescale 1ns / 1ps

package pfn_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;

  // Reset value of the cross length threshold.
  localparam logic [62:0] THR_RESET = 63'd4295;

  // What the back end has to do with one item.
  typedef enum logic [0:0] {
    JOB_CROSS,
    JOB_FEW
  } job_kind_t;

  // One queued item: job kind, first edge, edge to the new vertex and polygon end flag.
  typedef struct packed {
    job_kind_t         kind;
    logic              last;
    logic [2:0][32:0]  d;
    logic [2:0][32:0]  e;
  } pfn_job_t;

endpackage

/* hdl/polygon_face_normal_core.sv */
// Top level of the polygon face normal block.
// Instantiates pfn_front, pfn_queue and pfn_back; uses pfn_pkg.
//
// Usage:
//   Vertices enter on the in_ channel (valid/ready), Q16.16 coordinates and
//   a last flag on the final vertex of each polygon. Each polygon gives at
//   most one item on the out_ channel: a Q2.30 unit normal with status ok,
//   or zeros with status degenerate or too-few-vertices.
//   cfg_we writes the cross length threshold (Q32.32) from cfg_wdata; write
//   it only while the block is idle.
//   Timing: the front end takes one vertex a cycle while its two-entry queue
//   has room. The back end takes a new item only once it has finished the
//   last one; the shared 32x32 multiplier, a one bit a cycle square root and
//   three one bit a cycle divisions set how long a passing vertex takes.
//   Reset (rst_n low, synchronous) empties the queue, clears the vertex
//   count and the found flag, and restores the threshold to 4295.
//   A stalled receiver holds the result in the output register; the queue
//   keeps taking vertices until it fills, then in_ready falls.
`timescale 1ns / 1ps

module polygon_face_normal_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [62:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_vert_x,
  input  logic [31:0] in_vert_y,
  input  logic [31:0] in_vert_z,
  input  logic        in_last_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_norm_x,
  output logic [31:0] out_norm_y,
  output logic [31:0] out_norm_z,
  output logic [1:0]  out_status
);

  pfn_pkg::pfn_job_t push_job;
  pfn_pkg::pfn_job_t pop_job;
  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;

  // Vertex intake and edge setup.
  pfn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vert_x      (in_vert_x),
    .in_vert_y      (in_vert_y),
    .in_vert_z      (in_vert_z),
    .in_last_vertex (in_last_vertex),
    .job_valid      (push_valid),
    .job_ready      (push_ready),
    .job            (push_job)
  );

  // Decoupling queue.
  pfn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Cross product, threshold test and normalization.
  pfn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job        (pop_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_norm_x (out_norm_x),
    .out_norm_y (out_norm_y),
    .out_norm_z (out_norm_z),
    .out_status (out_status)
  );

endmodule

/* hdl/pfn_front.sv */
// Front end: takes vertices, keeps the first two and the first edge.
// Builds one pfn_pkg::pfn_job_t per item that needs work in the back end.
`timescale 1ns / 1ps

module pfn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_vert_x,
  input  logic [31:0]       in_vert_y,
  input  logic [31:0]       in_vert_z,
  input  logic              in_last_vertex,
  output logic              job_valid,
  input  logic              job_ready,
  output pfn_pkg::pfn_job_t job
);

  logic [1:0]        count_r, count_nxt;
  logic [2:0][31:0]  first_r;
  logic [2:0][31:0]  second_r;
  logic [2:0][32:0]  edge_r;
  logic [2:0][31:0]  vin;
  logic [2:0][32:0]  evec;
  logic              accept;

  assign vin = {in_vert_z, in_vert_y, in_vert_x};

  // Edge from the second vertex to the incoming one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      evec[i] = {vin[i][31], vin[i]} - {second_r[i][31], second_r[i]};
    end
  end

  // The queue slot decides acceptance; items that need no work are absorbed.
  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && ((count_r >= 2'd2) || in_last_vertex);

  always_comb begin
    job.kind = (count_r >= 2'd2) ? pfn_pkg::JOB_CROSS : pfn_pkg::JOB_FEW;
    job.last = in_last_vertex;
    job.d    = edge_r;
    job.e    = evec;
  end

  // Vertex count saturates at three and clears at the end of a polygon.
  always_comb begin
    count_nxt = count_r;
    if (in_last_vertex) begin
      count_nxt = 2'd0;
    end else if (count_r != 2'd3) begin
      count_nxt = count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      first_r  <= '0;
      second_r <= '0;
      edge_r   <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      if (count_r == 2'd0) begin
        first_r <= vin;
      end else if (count_r == 2'd1) begin
        second_r <= vin;
        for (int i = 0; i < 3; i++) begin
          edge_r[i] <= {vin[i][31], vin[i]} - {first_r[i][31], first_r[i]};
        end
      end
    end
  end

endmodule

/* hdl/pfn_queue.sv */
// Two-entry queue of pfn_pkg::pfn_job_t between the front and back ends.
// Lets either side stall without holding up the other.
`timescale 1ns / 1ps
`include "polygon_face_normal_core_defines.svh"

module pfn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  pfn_pkg::pfn_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pfn_pkg::pfn_job_t pop_job
);

  pfn_pkg::pfn_job_t mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `PFN_ASSERT_NEXT(a_q_grow, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "queue count lost a push")

endmodule

/* hdl/pfn_back.sv */
// Back end: cross product, threshold test and normalization on one shared multiplier.
// Takes pfn_pkg::pfn_job_t items from the queue and holds the result in an output register.
`timescale 1ns / 1ps
`include "polygon_face_normal_core_defines.svh"

module pfn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [62:0]       cfg_wdata,
  input  logic              job_valid,
  output logic              job_ready,
  input  pfn_pkg::pfn_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_norm_x,
  output logic [31:0]       out_norm_y,
  output logic [31:0]       out_norm_z,
  output logic [1:0]        out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_SQR, S_CMP, S_SHIFT, S_SUMSQ, S_SQRT, S_DIVLD, S_DIV, S_OUT
  } state_t;

  state_t              state_r;
  pfn_pkg::pfn_job_t   job_r;
  logic [62:0]         thr_r;
  logic                found_r;
  logic [4:0]          idx_r;
  logic [1:0]          k_r;
  logic signed [65:0]  c_r [3];
  logic signed [129:0] acc_r;
  logic [64:0]         m_r [3];
  logic [2:0]          neg_r;
  logic [63:0]         sq_x_r;
  logic [63:0]         root_r;
  logic [63:0]         bit_r;
  logic [31:0]         len_r;
  logic [31:0]         rem_r;
  logic [30:0]         nlo_r;
  logic [30:0]         q_r;
  logic [31:0]         norm_r [3];
  logic [1:0]          status_r;
  logic                out_valid_r;
  logic [63:0]         prod_r;
  logic                prod_vld_r;
  logic                prod_neg_r;
  logic [4:0]          prod_tag_r;

  logic [31:0]         mul_a, mul_b;
  logic                mul_go, mul_neg;
  logic signed [32:0]  op_a, op_b;
  logic [62:0]         sq_x;
  logic [64:0]         cm [3];
  logic                big;
  logic signed [65:0]  cterm;
  logic signed [129:0] sterm;
  logic [64:0]         orv;
  logic [61:0]         num;
  logic [32:0]         dt;
  logic [32:0]         dsub;
  logic                dge;
  logic [30:0]         q_nxt;
  logic [63:0]         rb;

  function automatic logic [31:0] mag32(input logic [32:0] v);
    logic [32:0] t;
    t = v[32] ? (~v + 33'd1) : v;
    return t[31:0];
  endfunction

  function automatic logic [64:0] mag65(input logic [65:0] v);
    logic [65:0] t;
    t = v[65] ? (~v + 66'd1) : v;
    return t[64:0];
  endfunction

  // Magnitudes of the cross product components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = mag65(c_r[i]);
    end
    big = (cm[0][64:63] != 2'b00) || (cm[1][64:63] != 2'b00) || (cm[2][64:63] != 2'b00);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    sq_x    = '0;
    mul_a   = '0;
    mul_b   = '0;
    mul_go  = 1'b0;
    mul_neg = 1'b0;
    case (state_r)
      S_CROSS: begin
        case (idx_r[2:0])
          3'd0: begin op_a = job_r.d[1]; op_b = job_r.e[2]; end
          3'd1: begin op_a = job_r.d[2]; op_b = job_r.e[1]; end
          3'd2: begin op_a = job_r.d[2]; op_b = job_r.e[0]; end
          3'd3: begin op_a = job_r.d[0]; op_b = job_r.e[2]; end
          3'd4: begin op_a = job_r.d[0]; op_b = job_r.e[1]; end
          3'd5: begin op_a = job_r.d[1]; op_b = job_r.e[0]; end
          default: ;
        endcase
        mul_a   = mag32(op_a);
        mul_b   = mag32(op_b);
        mul_neg = op_a[32] ^ op_b[32] ^ idx_r[0];
        mul_go  = (idx_r < 5'd6);
      end
      S_SQR: begin
        if (idx_r[3:2] == 2'd3) begin
          sq_x = thr_r;
        end else begin
          sq_x = cm[idx_r[3:2]][62:0];
        end
        case (idx_r[1:0])
          2'd0: begin mul_a = sq_x[31:0]; mul_b = sq_x[31:0]; end
          2'd1: begin mul_a = {1'b0, sq_x[62:32]}; mul_b = sq_x[31:0]; end
          default: begin mul_a = {1'b0, sq_x[62:32]}; mul_b = {1'b0, sq_x[62:32]}; end
        endcase
        mul_go = !big && !idx_r[4];
      end
      S_SUMSQ: begin
        mul_go = (idx_r < 5'd3);
        if (mul_go) begin
          mul_a = m_r[idx_r[1:0]][31:0];
          mul_b = m_r[idx_r[1:0]][31:0];
        end
      end
      default: ;
    endcase
  end

  // Terms that the accumulators add for the product now leaving the multiplier.
  always_comb begin
    cterm = $signed({2'b00, prod_r});
    if (prod_neg_r) begin
      cterm = -cterm;
    end
    case (prod_tag_r[1:0])
      2'd0:    sterm = $signed({66'd0, prod_r});
      2'd1:    sterm = $signed({33'd0, prod_r, 33'd0});
      default: sterm = $signed({2'd0, prod_r, 64'd0});
    endcase
    if (prod_tag_r[3:2] == 2'd3) begin
      sterm = -sterm;
    end
  end

  // Normalization shift, square root and division datapath.
  always_comb begin
    orv   = m_r[0] | m_r[1] | m_r[2];
    rb    = root_r + bit_r;
    num   = {1'b0, m_r[k_r][30:0], 30'd0} + {31'd0, len_r[31:1]};
    dt    = {rem_r, nlo_r[30]};
    dsub  = dt - {1'b0, len_r};
    dge   = (dt >= {1'b0, len_r});
    q_nxt = {q_r[29:0], dge};
  end

  // Product register of the shared multiplier.
  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    prod_neg_r <= mul_neg;
    prod_tag_r <= idx_r;
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mul_go;
    end
  end

  // Sequencer with its registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= pfn_pkg::THR_RESET;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            if (job.kind == pfn_pkg::JOB_FEW) begin
              norm_r      <= '{default: '0};
              status_r    <= pfn_pkg::ST_FEW;
              out_valid_r <= 1'b1;
              found_r     <= 1'b0;
              state_r     <= S_OUT;
            end else if (found_r) begin
              if (job.last) begin
                found_r <= 1'b0;
              end
            end else begin
              idx_r   <= '0;
              c_r     <= '{default: '0};
              state_r <= S_CROSS;
            end
          end
        end
        S_CROSS: begin
          if (prod_vld_r) begin
            c_r[prod_tag_r[2:1]] <= c_r[prod_tag_r[2:1]] + cterm;
          end
          if (idx_r == 5'd6) begin
            idx_r   <= '0;
            acc_r   <= '0;
            state_r <= S_SQR;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        S_SQR: begin
          if (prod_vld_r) begin
            acc_r <= acc_r + sterm;
          end
          if (big) begin
            m_r     <= cm;
            neg_r   <= {c_r[2][65], c_r[1][65], c_r[0][65]};
            found_r <= !job_r.last;
            state_r <= S_SHIFT;
          end else if (idx_r == 5'd16) begin
            state_r <= S_CMP;
          end else if (idx_r[1:0] == 2'd2) begin
            idx_r <= idx_r + 5'd2;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        S_CMP: begin
          if (acc_r > 0) begin
            m_r     <= cm;
            neg_r   <= {c_r[2][65], c_r[1][65], c_r[0][65]};
            found_r <= !job_r.last;
            state_r <= S_SHIFT;
          end else if (job_r.last) begin
            norm_r      <= '{default: '0};
            status_r    <= pfn_pkg::ST_DEGEN;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // Bring the largest magnitude into [2^30, 2^31), one bit a cycle.
          if (orv[64:31] != '0) begin
            for (int i = 0; i < 3; i++) begin
              m_r[i] <= m_r[i] >> 1;
            end
          end else if (!orv[30] && (orv != '0)) begin
            for (int i = 0; i < 3; i++) begin
              m_r[i] <= m_r[i] << 1;
            end
          end else begin
            idx_r   <= '0;
            sq_x_r  <= '0;
            state_r <= S_SUMSQ;
          end
        end
        S_SUMSQ: begin
          sq_x_r <= sq_x_r + (prod_vld_r ? prod_r : 64'd0);
          if (idx_r == 5'd3) begin
            root_r  <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            state_r <= S_SQRT;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        S_SQRT: begin
          // Digit-by-digit integer square root, one result bit a cycle.
          if (bit_r == '0) begin
            len_r   <= (root_r[31:0] == '0) ? 32'd1 : root_r[31:0];
            k_r     <= '0;
            state_r <= S_DIVLD;
          end else begin
            if (sq_x_r >= rb) begin
              sq_x_r <= sq_x_r - rb;
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_DIVLD: begin
          rem_r   <= {1'b0, num[61:31]};
          nlo_r   <= num[30:0];
          q_r     <= '0;
          idx_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle.
          rem_r <= dge ? dsub[31:0] : dt[31:0];
          nlo_r <= {nlo_r[29:0], 1'b0};
          q_r   <= q_nxt;
          if (idx_r == 5'd30) begin
            norm_r[k_r] <= neg_r[k_r] ? (32'd0 - {1'b0, q_nxt}) : {1'b0, q_nxt};
            if (k_r == 2'd2) begin
              status_r    <= pfn_pkg::ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_DIVLD;
            end
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_norm_x = norm_r[0];
  assign out_norm_y = norm_r[1];
  assign out_norm_z = norm_r[2];
  assign out_status = status_r;

  `PFN_ASSERT_NOW(a_ok_range, out_valid_r && (status_r == pfn_pkg::ST_OK), ($signed(norm_r[0]) <= 32'sd1073741824) && ($signed(norm_r[0]) >= -32'sd1073741824) && ($signed(norm_r[2]) <= 32'sd1073741824) && ($signed(norm_r[2]) >= -32'sd1073741824), "unit normal component out of range")
  `PFN_ASSERT_NOW(a_fail_zero, out_valid_r && (status_r != pfn_pkg::ST_OK), (norm_r[0] == '0) && (norm_r[1] == '0) && (norm_r[2] == '0), "failure result carries a normal")
  `PFN_ASSERT_NOW(a_len_nz, state_r == S_DIVLD, len_r != '0, "divisor is zero")

endmodule
